// File: rtl/core/turnstile_gate_sequencer_core_defines.svh
// Assertion macros for the turnstile gate sequencer core.
// Included by files that check their own logic; no other dependencies.
`ifndef TURNSTILE_GATE_SEQUENCER_CORE_DEFINES_SVH
`define TURNSTILE_GATE_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define TGS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tgs assertion failed");
// Check a property on every rising edge, reset included.
`define TGS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tgs assertion failed");
`else
`define TGS_ASSERT(lbl, clk, rstn, prop)
`define TGS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/core/tgs_pkg.sv
// Types and constants of the turnstile gate sequencer.
// No dependencies; used by the channel interface users and the core.
`timescale 1ns / 1ps

package tgs_pkg;

  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned RegWidth     = 8;

  // register indexes
  localparam logic [2:0] RegLockShort = 3'd0;
  localparam logic [2:0] RegLockMid   = 3'd1;
  localparam logic [2:0] RegLockLong  = 3'd2;
  localparam logic [2:0] RegDebounce  = 3'd3;
  localparam logic [2:0] RegErrBuzz   = 3'd4;

  localparam logic [RegWidth-1:0] LockShortRst = 8'd3;
  localparam logic [RegWidth-1:0] LockMidRst   = 8'd6;
  localparam logic [RegWidth-1:0] LockLongRst  = 8'd10;
  localparam logic [RegWidth-1:0] DebounceRst  = 8'd10;
  localparam logic [RegWidth-1:0] ErrBuzzRst   = 8'd100;

  // drive bit positions
  localparam int unsigned DrvSol1 = 0;
  localparam int unsigned DrvSol2 = 1;
  localparam int unsigned DrvLed1 = 2;
  localparam int unsigned DrvLed2 = 3;
  localparam int unsigned DrvBuzz = 4;
  localparam int unsigned DrvBeat = 5;

  // phase codes as reported on the result beat
  localparam logic [3:0] PhInitCode     = 4'd0;
  localparam logic [3:0] PhSenseCode    = 4'd1;
  localparam logic [3:0] PhDeb1Code     = 4'd2;
  localparam logic [3:0] PhDeb2Code     = 4'd3;
  localparam logic [3:0] PhSetTimerCode = 4'd4;
  localparam logic [3:0] PhBuzzWaitCode = 4'd5;
  localparam logic [3:0] PhCheckCode    = 4'd6;
  localparam logic [3:0] PhOnCode       = 4'd7;
  localparam logic [3:0] PhTimingCode   = 4'd8;
  localparam logic [3:0] PhOffCode      = 4'd9;
  localparam logic [3:0] PhResetCode    = 4'd10;

  typedef enum logic [10:0] {
    PH_INIT      = 11'b000_0000_0001,
    PH_SENSE     = 11'b000_0000_0010,
    PH_DEB1      = 11'b000_0000_0100,
    PH_DEB2      = 11'b000_0000_1000,
    PH_SETTIMER  = 11'b000_0001_0000,
    PH_BUZZWAIT  = 11'b000_0010_0000,
    PH_CHECK     = 11'b000_0100_0000,
    PH_ON        = 11'b000_1000_0000,
    PH_TIMING    = 11'b001_0000_0000,
    PH_OFF       = 11'b010_0000_0000,
    PH_RESET     = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic grant1_n;
    logic grant2_n;
    logic sel_short_n;
    logic sel_mid_n;
    logic sel_long_n;
    logic prox_level;
    logic prox_event;
    logic lock_tick;
    logic ms_tick;
    logic beat_tick;
  } in_item_t;

  typedef struct packed {
    logic       solenoid1;
    logic       solenoid2;
    logic       gate1_led;
    logic       gate2_led;
    logic       buzzer;
    logic       heartbeat_led;
    logic [3:0] phase;
  } out_item_t;

  function automatic logic [3:0] phase_code(input phase_e ph);
    logic [3:0] code;
    case (ph)
      PH_INIT:     code = PhInitCode;
      PH_SENSE:    code = PhSenseCode;
      PH_DEB1:     code = PhDeb1Code;
      PH_DEB2:     code = PhDeb2Code;
      PH_SETTIMER: code = PhSetTimerCode;
      PH_BUZZWAIT: code = PhBuzzWaitCode;
      PH_CHECK:    code = PhCheckCode;
      PH_ON:       code = PhOnCode;
      PH_TIMING:   code = PhTimingCode;
      PH_OFF:      code = PhOffCode;
      PH_RESET:    code = PhResetCode;
      default:     code = PhResetCode;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/tgs_chan_if.sv
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is set per instance, usually from tgs_pkg.
`timescale 1ns / 1ps

interface tgs_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/turnstile_gate_sequencer_core.sv
// Turnstile gate sequencer: each accepted input beat gives one registered result beat.
// Throughput one beat per cycle; the whole step for a beat is evaluated in
// the accepting cycle and lands in the result register, which also decouples
// the two sides, so input is taken whenever the result slot is empty or drains.
// Reset (async, active low) returns to the init phase with all flags, counters
// and drives cleared and the configuration registers at their defaults.
`timescale 1ns / 1ps
`include "turnstile_gate_sequencer_core_defines.svh"

module turnstile_gate_sequencer_core #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tgs_chan_if.sink                           in_i,
  tgs_chan_if.source                         out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tgs_pkg::CfgAddrWidth-1:0]   paddr,
  input  logic [tgs_pkg::CfgDataWidth-1:0]   pwdata,
  output logic [tgs_pkg::CfgDataWidth-1:0]   prdata,
  output logic                               pready
);

  localparam int unsigned ExtW = (COUNT_WIDTH > tgs_pkg::RegWidth) ?
                                 COUNT_WIDTH : tgs_pkg::RegWidth;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  function automatic logic [COUNT_WIDTH-1:0] sat_count(
    input logic [tgs_pkg::RegWidth-1:0] v
  );
    logic [ExtW-1:0] ext;
    ext = ExtW'(v);
    if (ext > ExtW'(CountMax)) begin
      return CountMax;
    end
    return COUNT_WIDTH'(ext);
  endfunction

  // ---------------- configuration registers ----------------
  logic [tgs_pkg::RegWidth-1:0] lock_short_q, lock_mid_q, lock_long_q;
  logic [tgs_pkg::RegWidth-1:0] debounce_q, err_buzz_q;
  logic                         cfg_wr;
  logic [2:0]                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_short_q <= tgs_pkg::LockShortRst;
      lock_mid_q   <= tgs_pkg::LockMidRst;
      lock_long_q  <= tgs_pkg::LockLongRst;
      debounce_q   <= tgs_pkg::DebounceRst;
      err_buzz_q   <= tgs_pkg::ErrBuzzRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tgs_pkg::RegLockShort: lock_short_q <= pwdata[tgs_pkg::RegWidth-1:0];
        tgs_pkg::RegLockMid:   lock_mid_q   <= pwdata[tgs_pkg::RegWidth-1:0];
        tgs_pkg::RegLockLong:  lock_long_q  <= pwdata[tgs_pkg::RegWidth-1:0];
        tgs_pkg::RegDebounce:  debounce_q   <= pwdata[tgs_pkg::RegWidth-1:0];
        tgs_pkg::RegErrBuzz:   err_buzz_q   <= pwdata[tgs_pkg::RegWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tgs_pkg::RegLockShort: prdata = tgs_pkg::CfgDataWidth'(lock_short_q);
      tgs_pkg::RegLockMid:   prdata = tgs_pkg::CfgDataWidth'(lock_mid_q);
      tgs_pkg::RegLockLong:  prdata = tgs_pkg::CfgDataWidth'(lock_long_q);
      tgs_pkg::RegDebounce:  prdata = tgs_pkg::CfgDataWidth'(debounce_q);
      tgs_pkg::RegErrBuzz:   prdata = tgs_pkg::CfgDataWidth'(err_buzz_q);
      default:               prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  tgs_pkg::phase_e          phase_q, phase_d;
  logic                     g1_q, g1_d, g2_q, g2_d;
  logic                     loaded_q, loaded_d, expired_q, expired_d;
  logic                     running_q, running_d;
  logic [COUNT_WIDTH-1:0]   lock_q, lock_d, wait_q, wait_d, wait_dec;
  logic                     entered_q, entered_d, left_q, left_d;
  logic [5:0]               drv_q, drv_d;
  logic                     wait_over;

  logic                     in_fire, out_valid_q;
  tgs_pkg::out_item_t       out_data_q, out_data_d;
  tgs_pkg::in_item_t        it;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_fire    = in_i.valid & in_i.ready;
  assign it         = in_i.data;

  // one ms-tick countdown step, shared by debounce and buzz waits
  assign wait_dec  = ((wait_q != '0) && it.ms_tick) ? (wait_q - CountOne) : wait_q;
  assign wait_over = (wait_dec == '0);

  always_comb begin
    phase_d   = phase_q;
    g1_d      = g1_q;
    g2_d      = g2_q;
    loaded_d  = loaded_q;
    expired_d = expired_q;
    running_d = running_q;
    lock_d    = lock_q;
    wait_d    = wait_q;
    entered_d = entered_q;
    left_d    = left_q;
    drv_d     = drv_q;

    // proximity first
    if (it.prox_event) begin
      if (!it.prox_level && !left_q) begin
        entered_d = 1'b1;
      end
      if (it.prox_level && entered_d) begin
        left_d = 1'b1;
      end
      if (!g1_q && !g2_q) begin
        entered_d = 1'b0;
        left_d    = 1'b0;
      end
      if (entered_d && left_d) begin
        phase_d = tgs_pkg::PH_OFF;
      end
    end

    // then the lock tick; hold at one and flag expiry
    if (it.lock_tick && running_q) begin
      if (lock_q == CountOne) begin
        expired_d = 1'b1;
      end else begin
        lock_d = lock_q - CountOne;
      end
    end

    case (phase_d)
      tgs_pkg::PH_INIT: begin
        phase_d = tgs_pkg::PH_SENSE;
      end
      tgs_pkg::PH_SENSE: begin
        if (!it.grant1_n) begin
          wait_d  = sat_count(debounce_q);
          phase_d = tgs_pkg::PH_DEB1;
        end else if (!it.grant2_n) begin
          wait_d  = sat_count(debounce_q);
          phase_d = tgs_pkg::PH_DEB2;
        end
      end
      tgs_pkg::PH_DEB1: begin
        wait_d = wait_dec;
        if (wait_over) begin
          if (!it.grant1_n) begin
            g1_d    = 1'b1;
            phase_d = tgs_pkg::PH_SETTIMER;
          end else begin
            phase_d = tgs_pkg::PH_SENSE;
          end
        end
      end
      tgs_pkg::PH_DEB2: begin
        wait_d = wait_dec;
        if (wait_over) begin
          if (!it.grant2_n) begin
            g2_d    = 1'b1;
            phase_d = tgs_pkg::PH_SETTIMER;
          end else begin
            phase_d = tgs_pkg::PH_SENSE;
          end
        end
      end
      tgs_pkg::PH_SETTIMER: begin
        if (!g1_q && !g2_q) begin
          phase_d = tgs_pkg::PH_RESET;
        end else if (!it.sel_short_n) begin
          lock_d   = sat_count(lock_short_q);
          loaded_d = 1'b1;
          phase_d  = tgs_pkg::PH_CHECK;
        end else if (!it.sel_mid_n) begin
          lock_d   = sat_count(lock_mid_q);
          loaded_d = 1'b1;
          phase_d  = tgs_pkg::PH_CHECK;
        end else if (!it.sel_long_n) begin
          lock_d   = sat_count(lock_long_q);
          loaded_d = 1'b1;
          phase_d  = tgs_pkg::PH_CHECK;
        end else begin
          drv_d[tgs_pkg::DrvBuzz] = 1'b1;
          wait_d  = sat_count(err_buzz_q);
          phase_d = tgs_pkg::PH_BUZZWAIT;
        end
      end
      tgs_pkg::PH_BUZZWAIT: begin
        wait_d = wait_dec;
        if (wait_over) begin
          phase_d = tgs_pkg::PH_RESET;
        end
      end
      tgs_pkg::PH_CHECK: begin
        phase_d = ((g1_q || g2_q) && loaded_q) ? tgs_pkg::PH_ON : tgs_pkg::PH_RESET;
      end
      tgs_pkg::PH_ON: begin
        if (loaded_q && g1_q) begin
          drv_d[tgs_pkg::DrvSol1] = 1'b1;
          drv_d[tgs_pkg::DrvLed1] = 1'b1;
          drv_d[tgs_pkg::DrvBuzz] = 1'b1;
          running_d = 1'b1;
          phase_d   = tgs_pkg::PH_TIMING;
        end else if (loaded_q && g2_q) begin
          drv_d[tgs_pkg::DrvSol2] = 1'b1;
          drv_d[tgs_pkg::DrvLed2] = 1'b1;
          drv_d[tgs_pkg::DrvBuzz] = 1'b1;
          running_d = 1'b1;
          phase_d   = tgs_pkg::PH_TIMING;
        end else begin
          phase_d = tgs_pkg::PH_RESET;
        end
      end
      tgs_pkg::PH_TIMING: begin
        if (expired_d) begin
          expired_d = 1'b0;
          running_d = 1'b0;
          phase_d   = tgs_pkg::PH_OFF;
        end
      end
      tgs_pkg::PH_OFF: begin
        running_d = 1'b0;
        expired_d = 1'b0;
        drv_d[tgs_pkg::DrvSol1] = 1'b0;
        drv_d[tgs_pkg::DrvSol2] = 1'b0;
        phase_d = tgs_pkg::PH_RESET;
      end
      tgs_pkg::PH_RESET: begin
        g1_d      = 1'b0;
        g2_d      = 1'b0;
        loaded_d  = 1'b0;
        expired_d = 1'b0;
        entered_d = 1'b0;
        left_d    = 1'b0;
        lock_d    = '0;
        drv_d[tgs_pkg::DrvBuzz] = 1'b0;
        drv_d[tgs_pkg::DrvLed1] = 1'b0;
        drv_d[tgs_pkg::DrvLed2] = 1'b0;
        phase_d = tgs_pkg::PH_INIT;
      end
      default: begin
        phase_d = tgs_pkg::PH_RESET;
      end
    endcase

    if (it.beat_tick) begin
      drv_d[tgs_pkg::DrvBeat] = ~drv_d[tgs_pkg::DrvBeat];
    end

    out_data_d.solenoid1     = drv_d[tgs_pkg::DrvSol1];
    out_data_d.solenoid2     = drv_d[tgs_pkg::DrvSol2];
    out_data_d.gate1_led     = drv_d[tgs_pkg::DrvLed1];
    out_data_d.gate2_led     = drv_d[tgs_pkg::DrvLed2];
    out_data_d.buzzer        = drv_d[tgs_pkg::DrvBuzz];
    out_data_d.heartbeat_led = drv_d[tgs_pkg::DrvBeat];
    out_data_d.phase         = tgs_pkg::phase_code(phase_d);
  end

  // advance state only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tgs_pkg::PH_INIT;
      g1_q      <= 1'b0;
      g2_q      <= 1'b0;
      loaded_q  <= 1'b0;
      expired_q <= 1'b0;
      running_q <= 1'b0;
      lock_q    <= '0;
      wait_q    <= '0;
      entered_q <= 1'b0;
      left_q    <= 1'b0;
      drv_q     <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      g1_q      <= g1_d;
      g2_q      <= g2_d;
      loaded_q  <= loaded_d;
      expired_q <= expired_d;
      running_q <= running_d;
      lock_q    <= lock_d;
      wait_q    <= wait_d;
      entered_q <= entered_d;
      left_q    <= left_d;
      drv_q     <= drv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------- checks ----------------
  `TGS_ASSERT(a_sol_excl, clk_i, rst_ni, !(drv_q[tgs_pkg::DrvSol1] && drv_q[tgs_pkg::DrvSol2]))
  `TGS_ASSERT(a_run_phase, clk_i, rst_ni, running_q |-> (phase_q == tgs_pkg::PH_TIMING || phase_q == tgs_pkg::PH_OFF))
  `TGS_ASSERT(a_no_overrun, clk_i, rst_ni, !(out_valid_q && !out_o.ready && in_fire))
  `TGS_ASSERT(a_result_follows, clk_i, rst_ni, in_fire |=> out_valid_q)

endmodule
